>>> rtl/core/jsu_pkg.sv
// ============================================================================
// jsu_pkg
// Shared types, character codes and helper functions for the JSON string
// unescaper.
// ============================================================================
`default_nettype none

package jsu_pkg;

  // Largest number of output bytes that one input byte can produce.
  localparam int unsigned BURST_MAX = 4;

  // Character codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;

  // UTF-8 framing
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;
  localparam logic [7:0] UTF8_MASK6 = 8'h3F;

  // Bytes produced by one input transaction, in order from index 0.
  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      eos;    // last byte of the burst ends the string
  } jsu_burst_t;

  function automatic logic [7:0] simple_escape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      CH_N:    r = CH_LF;
      CH_T:    r = CH_TAB;
      CH_R:    r = CH_CR;
      CH_B:    r = CH_BS;
      CH_F:    r = CH_FF;
      default: r = c;
    endcase
    return r;
  endfunction

  // Hex digit value; anything that is not a hex digit counts as zero.
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [3:0] r;
    if (c inside {[8'h30:8'h39]}) begin
      r = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      r = 4'd0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/jsu_in_if.sv
// ============================================================================
// jsu_in_if
// Input channel: one raw string byte per transaction with a last-byte flag.
// ============================================================================
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_in;

  modport source (output valid, output in_byte, output last_in, input ready);
  modport sink   (input valid, input in_byte, input last_in, output ready);
endinterface

`default_nettype wire

>>> rtl/core/jsu_out_if.sv
// ============================================================================
// jsu_out_if
// Result channel: one decoded byte per transaction with an end-of-string flag.
// ============================================================================
`default_nettype none

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_string;

  modport source (output valid, output out_byte, output end_of_string, input ready);
  modport sink   (input valid, input out_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

>>> rtl/core/jsu_decode.sv
// ============================================================================
// jsu_decode
// Escape state machine: holds the escape mode, \u digit count, partial code
// point and held digit characters, and turns each accepted byte into a burst
// of zero to four output bytes.
// ============================================================================
`default_nettype none

module jsu_decode (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic [7:0]         in_byte,
  input  wire logic               last_in,
  output jsu_pkg::jsu_burst_t     burst
);

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_HEX    = 2'd2
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [7:0]  held_r   [3];
  logic [7:0]  held_nxt [3];

  logic [15:0] cp;
  logic [7:0]  seq [4];
  logic [1:0]  rlen;
  logic        skip;

  always_comb begin
    burst    = '0;
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    held_nxt = held_r;
    cp       = {acc_r[11:0], jsu_pkg::nibble_of(in_byte)};
    rlen     = cnt_r + 2'd1;
    skip     = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (2'(k) < cnt_r) seq[k] = held_r[k];
      else if (2'(k) == cnt_r && k < 3) seq[k] = in_byte;
      else seq[k] = 8'h00;
    end

    case (mode_r)
      MODE_ESC: begin
        if (in_byte == jsu_pkg::CH_U && !last_in) begin
          mode_nxt = MODE_HEX;
          cnt_nxt  = 2'd0;
          acc_nxt  = 16'd0;
        end else begin
          burst.bytes[0] = jsu_pkg::simple_escape(in_byte);
          burst.count    = 3'd1;
          mode_nxt       = MODE_NORMAL;
        end
      end
      MODE_HEX: begin
        if (cnt_r == 2'd3) begin
          // fourth digit: emit the code point as UTF-8
          if (cp[15:7] == '0) begin
            burst.bytes[0] = cp[7:0];
            burst.count    = 3'd1;
          end else if (cp[15:11] == '0) begin
            burst.bytes[0] = jsu_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]};
            burst.bytes[1] = jsu_pkg::UTF8_CONT | (cp[7:0] & jsu_pkg::UTF8_MASK6);
            burst.count    = 3'd2;
          end else begin
            burst.bytes[0] = jsu_pkg::UTF8_LEAD3 | {4'b0000, cp[15:12]};
            burst.bytes[1] = jsu_pkg::UTF8_CONT | ({2'b00, cp[11:6]} & jsu_pkg::UTF8_MASK6);
            burst.bytes[2] = jsu_pkg::UTF8_CONT | (cp[7:0] & jsu_pkg::UTF8_MASK6);
            burst.count    = 3'd3;
          end
          mode_nxt = MODE_NORMAL;
          cnt_nxt  = 2'd0;
          acc_nxt  = 16'd0;
        end else if (last_in) begin
          // string ended inside \u: 'u', then replay held chars and this byte
          burst.bytes[0] = jsu_pkg::CH_U;
          burst.count    = 3'd1;
          for (int k = 0; k < 3; k++) begin
            if (2'(k) < rlen && !skip) begin
              if (seq[k] == jsu_pkg::CH_BSLASH && 2'(k + 1) < rlen) begin
                burst.bytes[burst.count[1:0]] = jsu_pkg::simple_escape(seq[k+1]);
                skip = 1'b1;
              end else begin
                burst.bytes[burst.count[1:0]] = seq[k];
              end
              burst.count = burst.count + 3'd1;
            end else begin
              skip = 1'b0;
            end
          end
          mode_nxt = MODE_NORMAL;
        end else begin
          held_nxt[cnt_r] = in_byte;
          acc_nxt         = cp;
          cnt_nxt         = cnt_r + 2'd1;
        end
      end
      default: begin
        mode_nxt = MODE_NORMAL;
        if (in_byte == jsu_pkg::CH_BSLASH && !last_in) begin
          mode_nxt = MODE_ESC;
        end else begin
          burst.bytes[0] = in_byte;
          burst.count    = 3'd1;
        end
      end
    endcase

    if (last_in) begin
      mode_nxt  = MODE_NORMAL;
      cnt_nxt   = 2'd0;
      acc_nxt   = 16'd0;
      burst.eos = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      cnt_r  <= 2'd0;
      acc_r  <= 16'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
    end
  end

  // held characters are payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= held_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/jsu_drain.sv
// ============================================================================
// jsu_drain
// Burst register plus output register: stores the bytes of one input
// transaction and hands them to the result channel one per cycle when ready.
// ============================================================================
`default_nettype none

module jsu_drain (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,      // input transaction accepted
  input  wire jsu_pkg::jsu_burst_t burst,
  output logic                     space,     // can take a new burst now
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_byte,
  output logic                     out_eos
);

  logic [jsu_pkg::BURST_MAX-1:0][7:0] bytes_r;
  logic [2:0] bcnt_r;
  logic [1:0] bidx_r;
  logic       beos_r;
  logic       ovalid_r;
  logic [7:0] obyte_r;
  logic       oeos_r;
  logic       move;

  assign move  = (bcnt_r != 3'd0) && (!ovalid_r || out_ready);
  assign space = (bcnt_r == 3'd0) || (bcnt_r == 3'd1 && move);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r   <= 3'd0;
      bidx_r   <= 2'd0;
      ovalid_r <= 1'b0;
    end else begin
      if (load && burst.count != 3'd0) begin
        bcnt_r <= burst.count;
        bidx_r <= 2'd0;
      end else if (move) begin
        bcnt_r <= bcnt_r - 3'd1;
        bidx_r <= bidx_r + 2'd1;
      end
      if (move) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= burst.bytes;
      beos_r  <= burst.eos;
    end
    if (move) begin
      obyte_r <= bytes_r[bidx_r];
      oeos_r  <= beos_r && (bcnt_r == 3'd1);
    end
  end

  assign out_valid = ovalid_r;
  assign out_byte  = obyte_r;
  assign out_eos   = oeos_r;

endmodule

`default_nettype wire

>>> rtl/core/json_string_unescape.sv
// ============================================================================
// json_string_unescape
// JSON string body unescaper with \u to UTF-8 conversion.
// ============================================================================
//  - in_ch carries one raw byte of the string body per transaction, with
//    last_in set on the final byte. out_ch carries decoded bytes, with
//    end_of_string set on the final decoded byte of the string.
//  - Each input byte yields zero to four output bytes: plain bytes and
//    simple escapes give one, \u escapes give one to three UTF-8 bytes on
//    the fourth hex digit, a string cut off inside \u gives up to four.
//  - First output byte: via the burst register, then the output register.
//  - Throughput: one input byte per cycle while each byte gives at most one
//    output byte and out_ch.ready stays high; a longer burst holds the input
//    until its last byte moves to the output register.
//  - Receiver stall: output byte holds; input is still taken while the burst
//    register is empty, and in_ch.ready stays low while it holds bytes,
//    except in the cycle its last byte moves to the output register.
//  - Reset (rst_n low, synchronous) returns to plain copy mode and empties
//    the burst and output registers.
// ============================================================================
`default_nettype none

module json_string_unescape (
  input  wire logic  clk,
  input  wire logic  rst_n,
  jsu_in_if.sink     in_ch,
  jsu_out_if.source  out_ch
);

  jsu_pkg::jsu_burst_t burst;
  logic                space;
  logic                accept;

  // input side: take a byte whenever the burst register is free or frees now
  assign in_ch.ready = space;
  assign accept      = in_ch.valid && space;

  // escape state machine, updated once per input transaction
  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_ch.in_byte),
    .last_in (in_ch.last_in),
    .burst   (burst)
  );

  // burst storage and output register
  jsu_drain u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .burst     (burst),
    .space     (space),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_eos   (out_ch.end_of_string)
  );

endmodule

`default_nettype wire

>>> sim/jsu_tb_pkg.sv
// ============================================================================
// jsu_tb_pkg
// Scoreboard for the JSON string unescaper bench: predicts the decoded bytes
// of every accepted raw byte and compares them with the bytes that come out.
// ============================================================================
package jsu_tb_pkg;

  import jsu_pkg::*;

  typedef enum logic [1:0] {
    M_COPY = 2'd0,
    M_ESC  = 2'd1,
    M_HEX  = 2'd2
  } unesc_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } dec_byte_t;

  localparam int unsigned MAX_REPORTS = 10;

  class unescape_scoreboard;

    dec_byte_t   expected_q[$];

    // Predictor state
    unesc_mode_e mode;
    logic [1:0]  digits;
    logic [15:0] cp_acc;
    logic [7:0]  held[3];

    int unsigned raw_count;
    int unsigned decoded_count;
    int unsigned mismatch_count;
    int unsigned string_count;
    int unsigned ucode_count;
    int unsigned cutoff_count;

    function new();
      mode           = M_COPY;
      digits         = '0;
      cp_acc         = '0;
      foreach (held[i]) held[i] = '0;
      raw_count      = 0;
      decoded_count  = 0;
      mismatch_count = 0;
      string_count   = 0;
      ucode_count    = 0;
      cutoff_count   = 0;
    endfunction

    function logic [3:0] hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
      if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
      return 4'd0;
    endfunction

    function logic [7:0] short_escape(logic [7:0] c);
      case (c)
        CH_N:    return CH_LF;
        CH_T:    return CH_TAB;
        CH_R:    return CH_CR;
        CH_B:    return CH_BS;
        CH_F:    return CH_FF;
        default: return c;
      endcase
    endfunction

    function void push_byte(logic [7:0] b);
      dec_byte_t d;
      d.data = b;
      d.eos  = 1'b0;
      expected_q.push_back(d);
    endfunction

    function void push_utf8(logic [15:0] cp);
      if (cp < 16'h0080) begin
        push_byte(cp[7:0]);
      end else if (cp < 16'h0800) begin
        push_byte(UTF8_LEAD2 | {3'b000, cp[10:6]});
        push_byte(UTF8_CONT | {2'b00, cp[5:0]});
      end else begin
        push_byte(UTF8_LEAD3 | {4'b0000, cp[15:12]});
        push_byte(UTF8_CONT | {2'b00, cp[11:6]});
        push_byte(UTF8_CONT | {2'b00, cp[5:0]});
      end
    endfunction

    // String cut off inside \u: a literal 'u', then the held characters and
    // the final byte as plain text; only a two-character escape can form.
    function void push_cutoff(logic [7:0] last_b);
      logic [7:0] seq[4];
      int         len;
      int         i;
      for (i = 0; i < int'(digits); i++) seq[i] = held[i];
      seq[digits] = last_b;
      len = int'(digits) + 1;
      push_byte(CH_U);
      i = 0;
      while (i < len) begin
        if (seq[i] != CH_BSLASH || i + 1 >= len) begin
          push_byte(seq[i]);
          i++;
        end else begin
          push_byte(short_escape(seq[i + 1]));
          i += 2;
        end
      end
    endfunction

    // One accepted raw byte: advance the state, queue the decoded bytes.
    function void add_raw_byte(logic [7:0] b, logic last);
      dec_byte_t d;
      raw_count++;
      case (mode)
        M_ESC: begin
          if (b == CH_U && !last) begin
            mode   = M_HEX;
            digits = '0;
            cp_acc = '0;
          end else begin
            push_byte(short_escape(b));
            mode = M_COPY;
          end
        end
        M_HEX: begin
          if (digits == 2'd3) begin
            push_utf8({cp_acc[11:0], hex_value(b)});
            ucode_count++;
            mode   = M_COPY;
            digits = '0;
            cp_acc = '0;
          end else if (last) begin
            push_cutoff(b);
            cutoff_count++;
            mode   = M_COPY;
            digits = '0;
            cp_acc = '0;
          end else begin
            held[digits] = b;
            cp_acc       = {cp_acc[11:0], hex_value(b)};
            digits       = digits + 2'd1;
          end
        end
        default: begin
          mode = M_COPY;
          if (b == CH_BSLASH && !last) mode = M_ESC;
          else push_byte(b);
        end
      endcase
      if (last) begin
        mode   = M_COPY;
        digits = '0;
        cp_acc = '0;
        // every final byte yields at least one decoded byte
        d     = expected_q.pop_back();
        d.eos = 1'b1;
        expected_q.push_back(d);
        string_count++;
      end
    endfunction

    function void check_decoded(logic [7:0] b, logic eos);
      dec_byte_t d;
      decoded_count++;
      if (expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("ERROR: decoded byte %0d not expected: got %02h eos %0b",
                   decoded_count, b, eos);
      end else begin
        d = expected_q.pop_front();
        if (d.data !== b || d.eos !== eos) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("ERROR: decoded byte %0d: expected %02h eos %0b, got %02h eos %0b",
                     decoded_count, d.data, d.eos, b, eos);
        end
      end
    endfunction

  endclass

endpackage

>>> sim/tb_json_string_unescape.sv
// ============================================================================
// tb_json_string_unescape
// Self-checking bench for the JSON string unescaper. A few directed strings
// hit byte extremes, unknown escapes, a trailing backslash, \u with junk
// digits and strings cut off inside \u; then random strings mix plain bytes,
// escapes and \u code points of every UTF-8 length, with random source gaps
// and sink stalls. Every decoded byte is checked against a scoreboard.
// ============================================================================
module tb_json_string_unescape;

  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;
  import jsu_tb_pkg::*;

  localparam int unsigned RAW_TARGET   = 270;     // send strings until at least this many raw bytes
  localparam int unsigned DRAIN_CYCLES = 16;      // wait after the scoreboard empties, with margin
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic clk;
  logic rst_n;

  jsu_in_if  in_ch();
  jsu_out_if out_ch();

  json_string_unescape dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  unescape_scoreboard sb = new();

  logic [7:0]  str_q[$];     // raw bytes of the string being sent
  bit          calm_in;      // no source gaps for this string
  bit          calm_out;     // no sink stalls for this stretch
  int unsigned cycle_count;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length: mostly none, often a few cycles, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // --------------------------------------------------------------------------
  // String generation
  // --------------------------------------------------------------------------

  // Junk that lands in \u digit slots: backslash, 'u', non-hex, or anything.
  function automatic logic [7:0] junk_char();
    case ($urandom_range(0, 3))
      0:       return CH_BSLASH;
      1:       return CH_U;
      2:       return $urandom_range(0, 1) ? "G" : "z";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Hex digit in random case, now and then replaced by junk (non-hex junk counts as zero).
  function automatic logic [7:0] digit_char(logic [3:0] v);
    if ($urandom_range(0, 11) == 0) return junk_char();
    if (v < 4'd10) return 8'h30 + {4'b0000, v};
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'b0000, v} - 8'd10;
  endfunction

  function automatic logic [7:0] escape_char();
    case ($urandom_range(0, 7))
      0:       return CH_N;
      1:       return CH_T;
      2:       return CH_R;
      3:       return CH_B;
      4:       return CH_F;
      5:       return "/";
      6:       return "\"";
      default: return CH_BSLASH;
    endcase
  endfunction

  // \uXXXX with the code point biased toward zero, UTF-8 length boundaries
  // and the surrogate range.
  function automatic void add_unicode_escape();
    logic [15:0] cp;
    case ($urandom_range(0, 5))
      0: cp = 16'h0000;
      1: cp = 16'($urandom_range(16'h0001, 16'h007F));
      2: cp = 16'($urandom_range(16'h0080, 16'h07FF));
      3: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
      4: begin
        case ($urandom_range(0, 4))
          0:       cp = 16'h007F;
          1:       cp = 16'h0080;
          2:       cp = 16'h07FF;
          3:       cp = 16'h0800;
          default: cp = 16'hFFFF;
        endcase
      end
      default: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
    endcase
    str_q.push_back(CH_BSLASH);
    str_q.push_back(CH_U);
    str_q.push_back(digit_char(cp[15:12]));
    str_q.push_back(digit_char(cp[11:8]));
    str_q.push_back(digit_char(cp[7:4]));
    str_q.push_back(digit_char(cp[3:0]));
  endfunction

  // One random string. A quarter of them end badly: a lone backslash, or
  // inside a \u escape after zero to three more characters.
  function automatic void build_string();
    int   segs;
    int   r;
    int   k;
    bit   cut;
    logic [7:0] c;
    str_q.delete();
    cut  = ($urandom_range(0, 3) == 0);
    segs = cut ? $urandom_range(0, 4) : $urandom_range(1, 6);
    repeat (segs) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        // plain byte
        c = 8'($urandom_range(0, 255));
        if (c == CH_BSLASH) c = 8'h5B;
        str_q.push_back(c);
      end else if (r < 60) begin
        str_q.push_back(CH_BSLASH);
        str_q.push_back(escape_char());
      end else if (r < 80) begin
        add_unicode_escape();
      end else if (r < 88) begin
        // any escape but \u, mostly unknown ones, whose backslash is dropped
        c = 8'($urandom_range(0, 255));
        if (c == CH_U) c = 8'h76;
        str_q.push_back(CH_BSLASH);
        str_q.push_back(c);
      end else begin
        // noise, may open an escape of its own
        str_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    if (cut) begin
      k = $urandom_range(0, 4);
      str_q.push_back(CH_BSLASH);
      if (k > 0) begin
        str_q.push_back(CH_U);
        repeat (k - 1)
          str_q.push_back($urandom_range(0, 2) == 0 ? junk_char()
                                                    : digit_char(4'($urandom_range(0, 15))));
      end
    end
  endfunction

  function automatic void load_text(string s);
    str_q.delete();
    for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Source side
  // --------------------------------------------------------------------------

  // Send one raw byte; called right after a rising edge. Valid is only
  // dropped when a gap is taken, so back-to-back transactions keep it high.
  task automatic send_raw(input logic [7:0] b, input logic last);
    int gap;
    gap = calm_in ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.last_in <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.add_raw_byte(b, last);
  endtask

  task automatic send_string();
    for (int i = 0; i < str_q.size(); i++)
      send_raw(str_q[i], i == str_q.size() - 1);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.last_in = 1'b0;
    calm_in       = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed strings ----
    calm_in = 1'b1;
    str_q = {8'h00};                // lowest byte, one-byte string
    send_string();
    str_q = {8'hFF};                // highest byte
    send_string();
    calm_in = 1'b0;
    load_text("\\q\\");             // unknown escape, then backslash as final byte
    send_string();
    load_text("\\u\\0e9");          // backslash taken as a zero digit, two-byte UTF-8
    send_string();
    load_text("\\uFfFF");           // top code point, three-byte UTF-8, ends string
    send_string();
    load_text("\\uabc");            // cut off after two held digits: four bytes out
    send_string();
    load_text("\\u0\\t");           // cut off, replay forms an escape from a held backslash and the final byte
    send_string();

    // ---- random strings ----
    while (sb.raw_count < RAW_TARGET) begin
      calm_in = ($urandom_range(0, 4) == 0);
      build_string();
      send_string();
    end
    in_ch.valid <= 1'b0;

    // ---- drain ----
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d strings, %0d raw bytes in, %0d decoded bytes out.",
             sb.string_count, sb.raw_count, sb.decoded_count);
    $display("%0d \\u escapes decoded, %0d strings cut off inside \\u, %0d mismatches.",
             sb.ucode_count, sb.cutoff_count, sb.mismatch_count);
    if (sb.mismatch_count == 0 && sb.expected_q.size() == 0) begin
      $display("** json_string_unescape: PASSED **");
    end else begin
      $display("** json_string_unescape: FAILED **");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sink side: check each accepted transaction, then pick ready for the next
  // cycle. Calm stretches with no stalls come and go at random, phase by phase.
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    int phase;
    stall        = 0;
    phase        = 0;
    calm_out     = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        sb.check_decoded(out_ch.out_byte, out_ch.end_of_string);
      if (phase == 0) begin
        calm_out = ($urandom_range(0, 2) == 0);
        phase    = 64;
      end
      phase--;
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall = calm_out ? 0 : idle_len();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ERROR: timeout after %0d cycles, %0d decoded bytes still expected",
             cycle_count, sb.expected_q.size());
    $display("** json_string_unescape: FAILED **");
    $finish;
  end

endmodule
